// ----- hdl/pwm_ppd_pkg.sv -----
`timescale 1ns / 1ps

package pwm_ppd_pkg;

  localparam int unsigned DivW = 32;
  localparam int unsigned ModW = 16;
  localparam int unsigned DutyW = 16;
  localparam int unsigned IdxW = 3;
  localparam int unsigned LastIndex = 7;
  localparam logic [DivW-1:0] ModMax = 32'd65535;
  localparam logic [DivW-1:0] ClockReset = 32'd48000000;
  localparam logic [3:0] ChannelReset = 4'd0;
  localparam logic [3:0] LastChannel = 4'd7;
  localparam logic [DivW-1:0] HalfLsb = 32'h0000_8000;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadChannel = 2'd1;
  localparam logic [1:0] StatusZeroFreq = 2'd2;

  localparam logic CfgClockHz = 1'b0;
  localparam logic CfgChannel = 1'b1;

  typedef struct packed {
    logic [31:0] frequency_hz;
    logic [15:0] duty_fraction;
  } req_t;

  typedef struct packed {
    logic [2:0]  prescale_index;
    logic [15:0] period_modulo;
    logic [15:0] compare_value;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  num;
    logic [DivW-1:0]  den;
    logic [DutyW-1:0] duty;
    logic             zero_freq;
    logic             bad_channel;
  } cell_t;

endpackage

// ----- hdl/pwm_ppd_div_cell.sv -----
`timescale 1ns / 1ps

module pwm_ppd_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwm_ppd_pkg::cell_t  cell_i,
  output pwm_ppd_pkg::cell_t  cell_o
);

  logic                        valid_q;
  pwm_ppd_pkg::cell_t          data_q;
  pwm_ppd_pkg::cell_t          data_d;
  logic [pwm_ppd_pkg::DivW:0]  shifted;
  logic [pwm_ppd_pkg::DivW:0]  diff;

  always_comb begin
    data_d = cell_i;
    shifted = {cell_i.rem, cell_i.num[pwm_ppd_pkg::DivW-1]};
    diff = shifted - {1'b0, cell_i.den};
    if (!diff[pwm_ppd_pkg::DivW]) begin
      data_d.rem = diff[pwm_ppd_pkg::DivW-1:0];
      data_d.num = {cell_i.num[pwm_ppd_pkg::DivW-2:0], 1'b1};
    end else begin
      data_d.rem = shifted[pwm_ppd_pkg::DivW-1:0];
      data_d.num = {cell_i.num[pwm_ppd_pkg::DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    cell_o = data_q;
    cell_o.valid = valid_q;
  end

endmodule

// ----- hdl/pwm_ppd_post.sv -----
`timescale 1ns / 1ps

module pwm_ppd_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwm_ppd_pkg::cell_t  cell_i,
  output logic                valid_o,
  output pwm_ppd_pkg::res_t   res_o
);

  logic [pwm_ppd_pkg::IdxW-1:0]  idx_d, idx_q;
  logic [pwm_ppd_pkg::ModW-1:0]  mod_d, mod_q;
  logic [pwm_ppd_pkg::DutyW-1:0] duty_q;
  logic [1:0]                    status_d, status_q;
  logic                          zero_q;
  logic                          v1_q, v2_q;
  logic [pwm_ppd_pkg::DivW-1:0]  shifted;
  logic [pwm_ppd_pkg::DivW-1:0]  sum;
  pwm_ppd_pkg::res_t             res_d, res_q;

  always_comb begin
    idx_d = pwm_ppd_pkg::IdxW'(pwm_ppd_pkg::LastIndex);
    for (int j = pwm_ppd_pkg::LastIndex - 1; j >= 0; j--) begin
      if (cell_i.num <= (pwm_ppd_pkg::ModMax << j)) begin
        idx_d = pwm_ppd_pkg::IdxW'(j);
      end
    end
    shifted = cell_i.num >> idx_d;
    if (shifted == '0) begin
      mod_d = pwm_ppd_pkg::ModW'(1);
    end else if (shifted > pwm_ppd_pkg::ModMax) begin
      mod_d = pwm_ppd_pkg::ModMax[pwm_ppd_pkg::ModW-1:0];
    end else begin
      mod_d = shifted[pwm_ppd_pkg::ModW-1:0];
    end
    if (cell_i.zero_freq) begin
      status_d = pwm_ppd_pkg::StatusZeroFreq;
    end else if (cell_i.bad_channel) begin
      status_d = pwm_ppd_pkg::StatusBadChannel;
    end else begin
      status_d = pwm_ppd_pkg::StatusOk;
    end
  end

  always_comb begin
    sum = (pwm_ppd_pkg::DivW'(duty_q) * pwm_ppd_pkg::DivW'(mod_q)) + pwm_ppd_pkg::HalfLsb;
    res_d.status = status_q;
    if (zero_q) begin
      res_d.prescale_index = '0;
      res_d.period_modulo = '0;
      res_d.compare_value = '0;
    end else begin
      res_d.prescale_index = idx_q;
      res_d.period_modulo = mod_q;
      res_d.compare_value = sum[pwm_ppd_pkg::DivW-1:pwm_ppd_pkg::ModW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cell_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    mod_q <= mod_d;
    duty_q <= cell_i.duty;
    status_q <= status_d;
    zero_q <= cell_i.zero_freq;
    res_q <= res_d;
  end

  assign valid_o = v2_q;
  assign res_o = res_q;

endmodule

// ----- hdl/pwm_prescale_period_duty_calc.sv -----
`timescale 1ns / 1ps

// Takes one request in every clock cycle and delivers its result once the request has passed
// through the pipeline, with result_valid_o high for a single cycle; busy is never raised, and
// the result must be captured when it appears, since it cannot be held. The pipeline is
// a row of 32 divider cells, each resolving one quotient bit of clock over frequency, followed
// by one stage that picks the prescaler and clamps the modulo and one that forms the rounded
// compare value. Configuration sampled at the moment a request is taken applies to it.
module pwm_prescale_period_duty_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pwm_ppd_pkg::req_t  req_i,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output pwm_ppd_pkg::res_t  res_o
);

  logic [31:0]        clock_hz_q;
  logic [3:0]         channel_q;
  pwm_ppd_pkg::cell_t chain [pwm_ppd_pkg::DivW+1];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= pwm_ppd_pkg::ClockReset;
      channel_q <= pwm_ppd_pkg::ChannelReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pwm_ppd_pkg::CfgClockHz: clock_hz_q <= cfg_data_i;
        pwm_ppd_pkg::CfgChannel: channel_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    chain[0].valid = start && !busy;
    chain[0].rem = '0;
    chain[0].num = clock_hz_q;
    chain[0].den = req_i.frequency_hz;
    chain[0].duty = req_i.duty_fraction;
    chain[0].zero_freq = (req_i.frequency_hz == '0);
    chain[0].bad_channel = (channel_q > pwm_ppd_pkg::LastChannel);
  end

  for (genvar g = 0; g < pwm_ppd_pkg::DivW; g++) begin : g_cell
    pwm_ppd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  pwm_ppd_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (chain[pwm_ppd_pkg::DivW]),
    .valid_o (result_valid_o),
    .res_o   (res_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##34 result_valid_o)
    else $error("request did not produce a result on time");

  a_zero_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.status == pwm_ppd_pkg::StatusZeroFreq) |->
      (res_o.period_modulo == '0 && res_o.compare_value == '0))
    else $error("zero frequency result carries settings");

  a_modulo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.status != pwm_ppd_pkg::StatusZeroFreq) |->
      (res_o.period_modulo != '0 && res_o.compare_value <= res_o.period_modulo))
    else $error("modulo or compare value out of range");

endmodule

// ----- bench/pwm_prescale_period_duty_calc_test.sv -----
`timescale 1ns / 1ps

module pwm_prescale_period_duty_calc_test;

  localparam int unsigned Latency = 34;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomRequests = 1250;

  typedef struct {
    logic [31:0]       frequency_hz;
    logic [15:0]       duty_fraction;
    bit                has_fixed;
    pwm_ppd_pkg::res_t fixed;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  pwm_ppd_pkg::req_t req_i;
  logic              cfg_we_i;
  logic              cfg_addr_i;
  logic [31:0]       cfg_data_i;
  logic              result_valid_o;
  pwm_ppd_pkg::res_t res_o;

  logic [31:0]       clock_hz;
  logic [3:0]        channel_number;
  pwm_ppd_pkg::res_t pending_results[$];
  int unsigned       mismatches;
  int unsigned       idle_cycles;
  bit                timed_out;
  bit                no_gaps;

  pwm_prescale_period_duty_calc DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic pwm_ppd_pkg::res_t pwm_settings(logic [31:0] freq, logic [15:0] duty);
    pwm_ppd_pkg::res_t r;
    logic [63:0]       need;
    logic [31:0]       modulo;
    logic [47:0]       product;
    int unsigned       k;
    r = '0;
    if (freq == 32'd0) begin
      r.status = pwm_ppd_pkg::StatusZeroFreq;
      return r;
    end
    need = ({32'd0, clock_hz / freq} + 64'd65534) / 64'd65535;
    k = 0;
    while (k < pwm_ppd_pkg::LastIndex && need > (64'd1 << k)) k++;
    modulo = (clock_hz >> k) / freq;
    if (modulo < 32'd1) modulo = 32'd1;
    else if (modulo > pwm_ppd_pkg::ModMax) modulo = pwm_ppd_pkg::ModMax;
    product = ({32'd0, duty} * {16'd0, modulo}) + 48'h8000;
    r.prescale_index = k[2:0];
    r.period_modulo  = modulo[15:0];
    r.compare_value  = product[31:16];
    r.status         = (channel_number > pwm_ppd_pkg::LastChannel) ?
                       pwm_ppd_pkg::StatusBadChannel : pwm_ppd_pkg::StatusOk;
    return r;
  endfunction

  always @(posedge clk_i) begin
    pwm_ppd_pkg::res_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", res_o);
      end else begin
        want = pending_results.pop_front();
        if (res_o.prescale_index !== want.prescale_index
            || res_o.period_modulo !== want.period_modulo
            || res_o.compare_value !== want.compare_value
            || res_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("** pwm_prescale_period_duty_calc: FAILED **");
      $finish;
    end
  end

  task automatic write_register(logic index, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == pwm_ppd_pkg::CfgClockHz) clock_hz = value;
    else channel_number = value[3:0];
    @(posedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Each request is held until accepted; unless no_gaps is set, random gaps lower start first.
  task automatic send_request(logic [31:0] freq, logic [15:0] duty, bit has_fixed,
                              pwm_ppd_pkg::res_t fixed);
    pwm_ppd_pkg::res_t predicted;
    while (!no_gaps && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{frequency_hz: freq, duty_fraction: duty};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = pwm_settings(freq, duty);
    if (has_fixed && predicted != fixed) begin
      mismatches++;
      if (mismatches <= 10) $display("Table row disagrees: %p vs %p", fixed, predicted);
    end
    pending_results.push_back(predicted);
  endtask

  function automatic logic [31:0] random_frequency();
    case ($urandom_range(4))
      0: return $urandom_range(1, 100);
      1: return $urandom_range(1, 100000);
      2: return $urandom;
      3: return 32'hFFFF_FFFF >> $urandom_range(31);
      default: return $urandom_range(8) == 0 ? 32'd0 : $urandom_range(1, 5000);
    endcase
  endfunction

  initial begin
    stim_row_t   table_rows[$];
    logic [31:0] clocks[6];
    int unsigned n;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = pwm_ppd_pkg::CfgClockHz;
    cfg_data_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    no_gaps = 1'b0;
    clock_hz = pwm_ppd_pkg::ClockReset;
    channel_number = pwm_ppd_pkg::ChannelReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    table_rows.push_back('{32'd0, 16'hFFFF, 1,
                           '{3'd0, 16'd0, 16'd0, pwm_ppd_pkg::StatusZeroFreq}});
    table_rows.push_back('{32'd48000000, 16'd0, 1,
                           '{3'd0, 16'd1, 16'd0, pwm_ppd_pkg::StatusOk}});
    table_rows.push_back('{32'hFFFF_FFFF, 16'hFFFF, 1,
                           '{3'd0, 16'd1, 16'd1, pwm_ppd_pkg::StatusOk}});
    table_rows.push_back('{32'd1, 16'hFFFF, 1,
                           '{3'd7, 16'd65535, 16'd65534, pwm_ppd_pkg::StatusOk}});
    table_rows.push_back('{32'd1000, 16'h8000, 0, '0});
    table_rows.push_back('{32'd733, 16'h0001, 0, '0});
    table_rows.push_back('{32'd20000, 16'h4000, 0, '0});
    table_rows.push_back('{32'd732, 16'hC000, 0, '0});
    table_rows.push_back('{32'd5, 16'h7FFF, 0, '0});
    foreach (table_rows[i])
      send_request(table_rows[i].frequency_hz, table_rows[i].duty_fraction,
                   table_rows[i].has_fixed, table_rows[i].fixed);
    drain();
    write_register(pwm_ppd_pkg::CfgChannel, 32'd15);
    write_register(pwm_ppd_pkg::CfgClockHz, 32'd0);
    send_request(32'd1, 16'hFFFF, 1, '{3'd0, 16'd1, 16'd1, pwm_ppd_pkg::StatusBadChannel});
    send_request(32'd0, 16'hFFFF, 1, '{3'd0, 16'd0, 16'd0, pwm_ppd_pkg::StatusZeroFreq});
    drain();
    write_register(pwm_ppd_pkg::CfgClockHz, 32'hFFFF_FFFF);
    write_register(pwm_ppd_pkg::CfgChannel, 32'hFFFF_FFF8);
    send_request(32'd1, 16'hFFFF, 1,
                 '{3'd7, 16'd65535, 16'd65534, pwm_ppd_pkg::StatusBadChannel});
    send_request(32'hFFFF_FFFF, 16'hFFFF, 0, '0);
    send_request(32'd65535, 16'h8000, 0, '0);
    drain();

    clocks = '{32'd1, 32'd48000000, 32'hFFFF_FFFF, 32'd65535, 32'd8388480, 32'd0};
    for (int phase = 0; phase < 8; phase++) begin
      write_register(pwm_ppd_pkg::CfgClockHz, phase < 6 ? clocks[phase] : $urandom);
      write_register(pwm_ppd_pkg::CfgChannel, $urandom_range(15));
      no_gaps = (phase == 3);
      n = RandomRequests / 8;
      repeat (n) send_request(random_frequency(), 16'($urandom), 0, '0);
      drain();
    end

    repeat (Latency + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** pwm_prescale_period_duty_calc: PASSED **");
    else
      $display("** pwm_prescale_period_duty_calc: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pwm_ppd_pkg.sv
hdl/pwm_ppd_div_cell.sv
hdl/pwm_ppd_post.sv
hdl/pwm_prescale_period_duty_calc.sv
bench/pwm_prescale_period_duty_calc_test.sv
